// File: rtl/core/hcidf_pkg.sv
// Package for the HCI UART packet deframer.
// Holds the phase type, indicator codes, header positions and the result record.
// No dependencies.
`timescale 1ns / 1ps

package hcidf_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 17;
  localparam int unsigned REM_W  = 16;

  // Packet indicator bytes
  localparam logic [BYTE_W-1:0] IND_EVENT = 8'h04;
  localparam logic [BYTE_W-1:0] IND_ACL   = 8'h02;

  // Header positions that carry the length
  localparam logic [POS_W-1:0] POS_EVT_LEN    = 17'd1;
  localparam logic [POS_W-1:0] POS_ACL_LEN_LO = 17'd2;
  localparam logic [POS_W-1:0] POS_ACL_LEN_HI = 17'd3;

  // Packet kind codes as carried in the result
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_ACL   = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              packet_kind;
    logic [POS_W-1:0]  byte_position;
    logic              last_of_packet;
    logic              bad_indicator;
  } result_t;

endpackage

// File: rtl/core/hcidf_if.sv
// Stream interfaces for the HCI UART packet deframer: received bytes in, packet bytes out.
// Depends on hcidf_pkg for field widths.
`timescale 1ns / 1ps

interface hcidf_rx_if;
  logic                           valid;
  logic                           ready;
  logic [hcidf_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcidf_pkt_if;
  logic                           valid;
  logic                           ready;
  logic [hcidf_pkg::BYTE_W-1:0]   data_byte;
  logic                           packet_kind;
  logic [hcidf_pkg::POS_W-1:0]    byte_position;
  logic                           last_of_packet;
  logic                           bad_indicator;

  modport source (output valid, output data_byte, output packet_kind, output byte_position,
                  output last_of_packet, output bad_indicator, input ready);
  modport sink   (input valid, input data_byte, input packet_kind, input byte_position,
                  input last_of_packet, input bad_indicator, output ready);
endinterface

// File: rtl/core/hcidf_fsm.sv
// Packet state tracker of the HCI UART packet deframer: phase, kind, position, remaining length.
// Produces the result for each accepted byte other than an indicator combinationally. Depends on hcidf_pkg.
`timescale 1ns / 1ps

module hcidf_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [hcidf_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                          res_valid_o,
  output hcidf_pkg::result_t            res_o
);

  hcidf_pkg::phase_e              phase_q, phase_d;
  logic                           is_event_q, is_event_d;
  logic [hcidf_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [hcidf_pkg::REM_W-1:0]    rem_q, rem_d;

  logic                           is_ind;
  logic [hcidf_pkg::REM_W-1:0]    acl_len;
  logic [hcidf_pkg::REM_W-1:0]    rem_dec;
  logic                           hdr_end;
  logic                           hdr_last;
  logic                           pay_last;

  // Decode of the current byte against the header layout
  assign is_ind   = (rx_byte_i == hcidf_pkg::IND_EVENT) || (rx_byte_i == hcidf_pkg::IND_ACL);
  assign acl_len  = {rx_byte_i, rem_q[7:0]};
  assign rem_dec  = rem_q - 16'd1;
  assign hdr_end  = is_event_q ? (pos_q == hcidf_pkg::POS_EVT_LEN)
                               : (pos_q == hcidf_pkg::POS_ACL_LEN_HI);
  assign hdr_last = is_event_q ? (rx_byte_i == 8'd0) : (acl_len == 16'd0);
  assign pay_last = (rem_dec == 16'd0);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      case (phase_q)
        hcidf_pkg::PH_HEADER: begin
          if (hdr_end) begin
            phase_d = hdr_last ? hcidf_pkg::PH_IDLE : hcidf_pkg::PH_PAYLOAD;
          end
        end
        hcidf_pkg::PH_PAYLOAD: begin
          if (pay_last) begin
            phase_d = hcidf_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_d = is_ind ? hcidf_pkg::PH_HEADER : hcidf_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Result and packet counters
  always_comb begin
    res_valid_o          = 1'b0;
    res_o.data_byte      = rx_byte_i;
    res_o.packet_kind    = is_event_q ? hcidf_pkg::KIND_EVENT : hcidf_pkg::KIND_ACL;
    res_o.byte_position  = pos_q;
    res_o.last_of_packet = 1'b0;
    res_o.bad_indicator  = 1'b0;
    is_event_d           = is_event_q;
    pos_d                = pos_q;
    rem_d                = rem_q;
    case (phase_q)
      hcidf_pkg::PH_HEADER: begin
        res_valid_o          = accept_i;
        res_o.last_of_packet = hdr_end && hdr_last;
        if (accept_i) begin
          pos_d = pos_q + 17'd1;
          if (is_event_q && (pos_q == hcidf_pkg::POS_EVT_LEN)) begin
            rem_d = {8'd0, rx_byte_i};
          end
          if (!is_event_q && (pos_q == hcidf_pkg::POS_ACL_LEN_LO)) begin
            rem_d = {8'd0, rx_byte_i};
          end
          if (!is_event_q && (pos_q == hcidf_pkg::POS_ACL_LEN_HI)) begin
            rem_d = acl_len;
          end
        end
      end
      hcidf_pkg::PH_PAYLOAD: begin
        res_valid_o          = accept_i;
        res_o.last_of_packet = pay_last;
        if (accept_i) begin
          pos_d = pos_q + 17'd1;
          rem_d = rem_dec;
        end
      end
      default: begin
        // Idle: indicator opens a packet, anything else is flagged
        res_o.packet_kind   = 1'b0;
        res_o.byte_position = '0;
        res_o.bad_indicator = 1'b1;
        res_valid_o         = accept_i && !is_ind;
        if (accept_i && is_ind) begin
          is_event_d = (rx_byte_i == hcidf_pkg::IND_EVENT);
          pos_d      = '0;
          rem_d      = '0;
        end
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= hcidf_pkg::PH_IDLE;
      is_event_q <= 1'b0;
      pos_q      <= '0;
      rem_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      is_event_q <= is_event_d;
      pos_q      <= pos_d;
      rem_q      <= rem_d;
    end
  end

  // A payload byte is only expected while length remains
  a_payload_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == hcidf_pkg::PH_PAYLOAD |-> rem_q != 16'd0)
    else $error("payload phase with zero remaining length");

  // Header never runs past the high length byte
  a_header_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == hcidf_pkg::PH_HEADER |-> pos_q <= hcidf_pkg::POS_ACL_LEN_HI)
    else $error("header position out of range");

  // An accepted indicator opens a header at position zero
  a_indicator_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == hcidf_pkg::PH_IDLE && is_ind
      |=> phase_q == hcidf_pkg::PH_HEADER && pos_q == '0)
    else $error("indicator did not open a packet");

  // The last byte of a packet returns the tracker to idle
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_of_packet |=> phase_q == hcidf_pkg::PH_IDLE)
    else $error("packet end did not return to idle");

endmodule

// File: rtl/core/hci_uart_packet_deframer.sv
// Top level of the HCI UART (H4) packet deframer.
// Depends on hcidf_pkg, hcidf_if (hcidf_rx_if, hcidf_pkt_if) and hcidf_fsm.
`timescale 1ns / 1ps

// Accepts one received byte per clock and emits at most one packet byte per
// received byte, in the cycle after acceptance, from an output register. An
// indicator byte 0x04 (event) or 0x02 (ACL) produces no transaction; every
// following header and payload byte comes out with its packet kind, its
// position (first byte after the indicator is 0) and a last flag on the final
// byte. A zero-length packet ends at its last length byte. Any other byte seen
// while idle comes out once with bad_indicator set. Sustained rate is one byte
// per cycle; input ready drops only while the output register holds a
// transaction that the sink is not taking.

module hci_uart_packet_deframer (
  input  logic           clk_i,
  input  logic           rst_ni,
  hcidf_rx_if.sink       rx_i,
  hcidf_pkt_if.source    pkt_o
);

  logic                   accept;
  logic                   res_valid;
  hcidf_pkg::result_t     res;
  logic                   out_valid_q, out_valid_d;
  hcidf_pkg::result_t     out_q;

  // Input is taken whenever the output register is free or being drained
  assign rx_i.ready = !out_valid_q || pkt_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  hcidf_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_i.rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register
  assign out_valid_d = accept ? res_valid : (out_valid_q && !pkt_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

  assign pkt_o.valid          = out_valid_q;
  assign pkt_o.data_byte      = out_q.data_byte;
  assign pkt_o.packet_kind    = out_q.packet_kind;
  assign pkt_o.byte_position  = out_q.byte_position;
  assign pkt_o.last_of_packet = out_q.last_of_packet;
  assign pkt_o.bad_indicator  = out_q.bad_indicator;

endmodule

// File: tb/sv/hci_uart_packet_deframer_tb.sv
// Self-checking testbench for the HCI UART packet deframer.
// Depends on hcidf_pkg, hcidf_if and hci_uart_packet_deframer from the RTL;
// a scoreboard class predicts each packet byte from the accepted stream.
`timescale 1ns / 1ps

module hci_uart_packet_deframer_tb;

  // Longest quiet stretch in a correct run is the deliberate sink hold-off
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 500;

  typedef enum int unsigned {
    SINK_RANDOM,
    SINK_HOLD,
    SINK_OPEN
  } sink_mode_e;

  // Predicts the deframer output and holds the packet bytes still to come
  class deframe_scoreboard;
    hcidf_pkg::phase_e                 phase;
    bit                                in_event;
    logic [hcidf_pkg::POS_W-1:0]       next_pos;
    logic [hcidf_pkg::REM_W-1:0]       payload_left;
    hcidf_pkg::result_t                pending_bytes[$];
    int unsigned                       errors;
    int unsigned                       n_rx;
    int unsigned                       n_checked;
    int unsigned                       n_bad;
    int unsigned                       n_closed;

    function new();
      phase        = hcidf_pkg::PH_IDLE;
      in_event     = 1'b0;
      next_pos     = '0;
      payload_left = '0;
      errors       = 0;
      n_rx         = 0;
      n_checked    = 0;
      n_bad        = 0;
      n_closed     = 0;
    endfunction

    // Advance the deframer state by one byte; returns 1 when a byte comes out
    function bit predict_deframe(input logic [hcidf_pkg::BYTE_W-1:0] b,
                                 output hcidf_pkg::result_t r);
      bit last;
      bit hdr_done;
      r    = '0;
      last = 1'b0;
      case (phase)
        hcidf_pkg::PH_HEADER: begin
          if (in_event) begin
            if (next_pos == hcidf_pkg::POS_EVT_LEN) begin
              if (b == '0) last = 1'b1;
              else payload_left = {8'h00, b};
            end
          end else if (next_pos == hcidf_pkg::POS_ACL_LEN_LO) begin
            payload_left = {8'h00, b};
          end else if (next_pos == hcidf_pkg::POS_ACL_LEN_HI) begin
            payload_left = {b, payload_left[7:0]};
            if (payload_left == '0) last = 1'b1;
          end
          r.data_byte      = b;
          r.packet_kind    = in_event ? hcidf_pkg::KIND_EVENT : hcidf_pkg::KIND_ACL;
          r.byte_position  = next_pos;
          r.last_of_packet = last;
          hdr_done = (in_event && next_pos == hcidf_pkg::POS_EVT_LEN) ||
                     (!in_event && next_pos == hcidf_pkg::POS_ACL_LEN_HI);
          if (hdr_done) phase = last ? hcidf_pkg::PH_IDLE : hcidf_pkg::PH_PAYLOAD;
          next_pos = next_pos + 1'b1;
          return 1'b1;
        end
        hcidf_pkg::PH_PAYLOAD: begin
          payload_left = payload_left - 1'b1;
          last = (payload_left == '0);
          r.data_byte      = b;
          r.packet_kind    = in_event ? hcidf_pkg::KIND_EVENT : hcidf_pkg::KIND_ACL;
          r.byte_position  = next_pos;
          r.last_of_packet = last;
          if (last) phase = hcidf_pkg::PH_IDLE;
          next_pos = next_pos + 1'b1;
          return 1'b1;
        end
        default: begin
          // idle: an indicator opens a packet, anything else is flagged
          phase = hcidf_pkg::PH_IDLE;
          if (b == hcidf_pkg::IND_EVENT || b == hcidf_pkg::IND_ACL) begin
            in_event     = (b == hcidf_pkg::IND_EVENT);
            next_pos     = '0;
            payload_left = '0;
            phase        = hcidf_pkg::PH_HEADER;
            return 1'b0;
          end
          r.data_byte     = b;
          r.bad_indicator = 1'b1;
          return 1'b1;
        end
      endcase
    endfunction

    function void note_rx_byte(input logic [hcidf_pkg::BYTE_W-1:0] b);
      hcidf_pkg::result_t r;
      n_rx++;
      if (predict_deframe(b, r)) pending_bytes.push_back(r);
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_packet_byte(input hcidf_pkg::result_t got);
      hcidf_pkg::result_t want;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte %02h pos %0d bad %0b",
                                  got.data_byte, got.byte_position, got.bad_indicator));
        return;
      end
      want = pending_bytes.pop_front();
      n_checked++;
      if (want.bad_indicator) n_bad++;
      if (want.last_of_packet) n_closed++;
      if (got != want)
        report_mismatch($sformatf(
          "out #%0d got byte %02h kind %0b pos %0d last %0b bad %0b, want %02h %0b %0d %0b %0b",
          n_checked, got.data_byte, got.packet_kind, got.byte_position,
          got.last_of_packet, got.bad_indicator, want.data_byte, want.packet_kind,
          want.byte_position, want.last_of_packet, want.bad_indicator));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  hcidf_rx_if  rx_if();
  hcidf_pkt_if pkt_if();

  deframe_scoreboard sb = new();

  sink_mode_e  sink_mode   = SINK_RANDOM;
  bit          hold_active = 1'b0;
  int unsigned gap_pct     = 0;
  int unsigned quiet_cycles = 0;

  hci_uart_packet_deframer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .pkt_o  (pkt_if)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitor both channels at the edge; outputs belong to earlier inputs
  always @(posedge clk_i) begin
    hcidf_pkg::result_t got;
    if (rst_ni) begin
      if (pkt_if.valid && pkt_if.ready) begin
        got.data_byte      = pkt_if.data_byte;
        got.packet_kind    = pkt_if.packet_kind;
        got.byte_position  = pkt_if.byte_position;
        got.last_of_packet = pkt_if.last_of_packet;
        got.bad_indicator  = pkt_if.bad_indicator;
        sb.check_packet_byte(got);
      end
      if (rx_if.valid && rx_if.ready) sb.note_rx_byte(rx_if.rx_byte);
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (pkt_if.valid && pkt_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d bytes outstanding",
               WATCHDOG_LIMIT, sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // Output sink: random stalls, one long hold-off, or always ready
  initial begin
    pkt_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      case (sink_mode)
        SINK_HOLD: begin
          pkt_if.ready <= 1'b0;
          hold_active = 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_active = 1'b0;
          sink_mode = SINK_RANDOM;
        end
        SINK_OPEN: begin
          pkt_if.ready <= 1'b1;
          @(posedge clk_i);
        end
        default: begin
          pkt_if.ready <= 1'b1;
          repeat ($urandom_range(1, 60)) @(posedge clk_i);
          if (sink_mode == SINK_RANDOM) begin
            pkt_if.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk_i);
          end
        end
      endcase
    end
  end

  // Offer one byte, maybe after an idle burst, and wait for its transaction
  task automatic send_byte(input logic [hcidf_pkg::BYTE_W-1:0] b);
    if ($urandom_range(0, 99) < gap_pct) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= 8'($urandom);
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
  endtask

  // Complete packet with random code/handle and payload
  task automatic send_packet(input bit acl, input int unsigned len);
    if (acl) begin
      send_byte(hcidf_pkg::IND_ACL);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      send_byte(len[7:0]);
      send_byte(len[15:8]);
    end else begin
      send_byte(hcidf_pkg::IND_EVENT);
      send_byte(8'($urandom));
      send_byte(len[7:0]);
    end
    repeat (len) send_byte(8'($urandom));
  endtask

  function automatic int unsigned pick_len(input bit acl);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 88) return $urandom_range(1, 24);
    return acl ? $urandom_range(250, 300) : $urandom_range(200, 255);
  endfunction

  // Stop offering bytes until every predicted output has arrived
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    // bad indicators at both ends of the byte range
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h03);
    // zero-length event ends at its length byte
    send_byte(hcidf_pkg::IND_EVENT); send_byte(8'hFF); send_byte(8'h00);
    // one-byte event
    send_byte(hcidf_pkg::IND_EVENT); send_byte(8'h00); send_byte(8'h01); send_byte(8'hAA);
    // zero-length ACL ends at the high length byte
    send_byte(hcidf_pkg::IND_ACL); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h00); send_byte(8'h00);
    // two-byte ACL
    send_byte(hcidf_pkg::IND_ACL); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h02); send_byte(8'h00); send_byte(8'h55); send_byte(8'hFF);
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned start_rx;
    int unsigned next_retune;
    int unsigned r;
    bit          acl;
    start_rx    = sb.n_rx;
    next_retune = 0;
    while (sb.n_rx - start_rx < n_items) begin
      // switch idling density now and then, including idle-free stretches
      if (sb.n_rx - start_rx >= next_retune) begin
        r = $urandom_range(0, 2);
        gap_pct = (r == 0) ? 0 : ((r == 1) ? 10 : 35);
        next_retune = sb.n_rx - start_rx + 100;
      end
      r   = $urandom_range(0, 99);
      acl = 1'($urandom_range(0, 1));
      if (r < 82) begin
        send_packet(acl, pick_len(acl));
      end else if (r < 92) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        // truncated header; the following bytes get absorbed into it
        send_byte(acl ? hcidf_pkg::IND_ACL : hcidf_pkg::IND_EVENT);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 20;
    run_directed();
    wait_drained();

    // long sink hold-off while the source keeps pushing an event packet
    sink_mode = SINK_HOLD;
    while (!hold_active) @(posedge clk_i);
    gap_pct = 0;
    send_packet(1'b0, 30);
    send_byte(8'hC3);

    run_random(RANDOM_ITEMS);
    wait_drained();

    // final stretch without idling, ending in a maximum-length event packet
    sink_mode = SINK_OPEN;
    gap_pct   = 0;
    repeat (4) send_packet(1'b1, pick_len(1'b1));
    send_packet(1'b0, 255);
    send_byte(8'h7E);
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("run: %0d bytes in, %0d bytes out checked, %0d packets closed",
             sb.n_rx, sb.n_checked, sb.n_closed);
    $display("run: %0d bad indicators, %0d mismatches", sb.n_bad, sb.errors);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
